// ===== rtl/core/gfdl_pkg.sv =====
// Shared types, constants and a helper function for the gliding feedback delay line.
package gfdl_pkg;

  localparam int unsigned DEPTH_DEF       = 48000;
  localparam int unsigned GLITCH_SPAN_DEF = 2000;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DRY_W    = 18;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned Q15_SHIFT = 15;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ECHO   = 2'd1,
    MODE_SLAP   = 2'd2,
    MODE_GLITCH = 2'd3
  } delay_mode_t;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_LENGTH  = 2'd1,
    REG_GAIN    = 2'd2,
    REG_DIVIDER = 2'd3
  } reg_index_t;

  localparam logic [2:0] DIVIDER_RESET = 3'd2;

  // Residues of the random word that the glitch stepping needs.
  typedef struct packed {
    logic       div13;
    logic [1:0] mod3;
  } rnd_res_t;

  // 2^12 is 1 mod 39, so fold 12-bit chunks, then reduce mod 39 by a
  // reciprocal multiply; both residues follow from the mod-39 value.
  function automatic rnd_res_t rnd_residue(input logic [31:0] rnd);
    logic [13:0] fold1;
    logic [12:0] fold2;
    logic [25:0] prod39;
    logic [6:0]  quo39;
    logic [12:0] mul39;
    logic [5:0]  rem39;
    logic [12:0] prod3;
    logic [3:0]  quo3;
    rnd_res_t    res;
    fold1  = 14'(rnd[11:0]) + 14'(rnd[23:12]) + 14'(rnd[31:24]);
    fold2  = 13'(fold1[11:0]) + 13'(fold1[13:12]);
    prod39 = 26'(fold2) * 26'(6722);
    quo39  = prod39[24:18];
    mul39  = 13'(quo39) * 13'(39);
    rem39  = 6'(fold2 - mul39);
    prod3  = 13'(rem39) * 13'(171);
    quo3   = prod3[12:9];
    res.mod3  = 2'(rem39 - 6'(quo3) * 6'd3);
    res.div13 = (rem39 == 6'd0) || (rem39 == 6'd13) || (rem39 == 6'd26);
    return res;
  endfunction

endpackage

// ===== rtl/core/gliding_feedback_delay_line_top.sv =====
// Echo stage with a gliding read offset over a circular sample memory.
//
// The block takes one signed sample per transfer and returns one saturated
// sample per transfer, in order. It sustains one transfer per clock while
// in_stall is low. The transfer captures the sample into stage 0. Stage 0
// then updates the offset and reads the memory into stage 1. Stage 1 sums,
// saturates, writes back and loads the output register.
// The rate is set by the read-sum-scale-write loop around the single echo
// memory: the word written for one sample can be the one read by the very
// next sample (read offset of one), so the written word is forwarded around
// the memory's registered read. After reset the block sweeps all DEPTH
// memory words to zero, one word per cycle, and holds in_stall high during
// that sweep; configuration writes are taken at any time. Configuration is
// meant to change only while no sample is in flight. A block_start transfer
// recomputes the target offset from delay_length and the glitch offset
// (random_word picks the glitch step in glitch mode); the live offset then
// moves one sample toward the target every glide_divider samples (a divider
// of zero acts as one).
module gliding_feedback_delay_line_top #(
  parameter int unsigned DEPTH       = gfdl_pkg::DEPTH_DEF,
  parameter int unsigned GLITCH_SPAN = gfdl_pkg::GLITCH_SPAN_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [gfdl_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [gfdl_pkg::DRY_W-1:0]     sample_in,
  input  logic                                  block_start,
  input  logic [31:0]                           random_word,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gfdl_pkg::SAMPLE_W-1:0]  sample_out
);

  localparam int unsigned OW          = $clog2(DEPTH);
  localparam int unsigned GLITCH_STEP = GLITCH_SPAN / 3;
  localparam int unsigned GW          = $clog2(GLITCH_SPAN + GLITCH_STEP + 1) + 1;
  localparam int unsigned TW          = ((GW > 17) ? GW : 17) + 1;
  localparam int unsigned SW          = gfdl_pkg::SAMPLE_W;
  localparam int unsigned DW          = gfdl_pkg::DRY_W;
  localparam int unsigned PW          = DW + 17;
  localparam logic [OW-1:0] LAST      = OW'(DEPTH - 1);

  // Configuration registers
  gfdl_pkg::delay_mode_t delay_mode;
  logic [15:0]           delay_length;
  logic [15:0]           feedback_gain;
  logic [2:0]            glide_divider;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_mode    <= gfdl_pkg::MODE_OFF;
      delay_length  <= '0;
      feedback_gain <= '0;
      glide_divider <= gfdl_pkg::DIVIDER_RESET;
    end else if (cfg_we) begin
      unique case (gfdl_pkg::reg_index_t'(cfg_index))
        gfdl_pkg::REG_MODE:    delay_mode    <= gfdl_pkg::delay_mode_t'(cfg_data[1:0]);
        gfdl_pkg::REG_LENGTH:  delay_length  <= cfg_data[15:0];
        gfdl_pkg::REG_GAIN:    feedback_gain <= cfg_data[15:0];
        gfdl_pkg::REG_DIVIDER: glide_divider <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clearing sweep after reset
  logic          clearing;
  logic [OW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + OW'(1);
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // The whole pipe advances when the output register is free or drained.
  logic adv;
  logic in_xfer;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = clearing || !adv;
  assign in_xfer  = in_valid && !in_stall;

  // Stage 0: capture the transfer and reduce the random word.
  logic                   s0_valid;
  logic signed [DW-1:0]   s0_dry;
  logic                   s0_bs;
  gfdl_pkg::rnd_res_t     s0_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_dry <= sample_in;
      s0_bs  <= block_start;
      s0_res <= gfdl_pkg::rnd_residue(random_word);
    end
  end

  // Offset state
  logic signed [GW-1:0] glitch;
  logic [OW-1:0]        target;
  logic [OW-1:0]        current;
  logic [2:0]           phase;
  logic [OW-1:0]        wp;

  logic signed [GW-1:0] glitch_next;
  logic [OW-1:0]        target_next;
  logic [OW-1:0]        current_next;
  logic [2:0]           phase_next;
  logic [OW-1:0]        wp_next;
  logic [OW-1:0]        cur_base;
  logic [2:0]           phase_base;
  logic [2:0]           div;
  logic signed [GW-1:0] glitch_step;
  logic signed [TW-1:0] tgt_sum;
  logic [OW:0]          rd_diff;
  logic [OW-1:0]        rd_addr;

  always_comb begin
    glitch_step = glitch;
    if (delay_mode == gfdl_pkg::MODE_GLITCH) begin
      if (s0_res.div13) begin
        if (s0_res.mod3 == 2'd0 && glitch < $signed(GW'(GLITCH_SPAN))) begin
          glitch_step = glitch + $signed(GW'(GLITCH_STEP));
        end else if (s0_res.mod3 == 2'd1 && glitch > -$signed(GW'(GLITCH_SPAN))) begin
          glitch_step = glitch - $signed(GW'(GLITCH_STEP));
        end
      end
    end else begin
      glitch_step = '0;
    end
    tgt_sum = $signed(TW'({1'b0, delay_length})) + TW'(glitch_step);

    glitch_next = glitch;
    target_next = target;
    cur_base    = current;
    phase_base  = phase;
    if (s0_bs) begin
      phase_base  = '0;
      glitch_next = glitch_step;
      priority if (delay_mode == gfdl_pkg::MODE_OFF) begin
        cur_base    = '0;
        target_next = '0;
      end else if (tgt_sum < $signed(TW'(0))) begin
        target_next = '0;
        glitch_next = '0;
      end else if (tgt_sum >= $signed(TW'(DEPTH))) begin
        target_next = LAST;
        glitch_next = '0;
      end else begin
        target_next = tgt_sum[OW-1:0];
      end
    end

    // On phase zero, step the live offset one sample toward the target.
    current_next = cur_base;
    if (phase_base == 3'd0) begin
      if (cur_base < target_next) begin
        current_next = cur_base + OW'(1);
      end else if (cur_base > target_next) begin
        current_next = cur_base - OW'(1);
      end
    end

    div        = (glide_divider == 3'd0) ? 3'd1 : glide_divider;
    phase_next = phase_base + 3'd1;
    if (({1'b0, phase_base} + 4'd1) >= {1'b0, div}) begin
      phase_next = '0;
    end

    wp_next = (wp == LAST) ? '0 : wp + OW'(1);

    rd_diff = {1'b0, wp} - {1'b0, current_next};
    rd_addr = rd_diff[OW] ? OW'(rd_diff + (OW+1)'(DEPTH)) : rd_diff[OW-1:0];
  end

  logic s0_go;
  assign s0_go = adv && s0_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      glitch  <= '0;
      target  <= '0;
      current <= '0;
      phase   <= '0;
      wp      <= '0;
    end else if (s0_go) begin
      glitch  <= glitch_next;
      target  <= target_next;
      current <= current_next;
      phase   <= phase_next;
      wp      <= wp_next;
    end
  end

  // Echo memory: one write port, one registered read port.
  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] mem_q;
  logic          mem_we;
  logic [OW-1:0] mem_wa;
  logic [SW-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Stage 1: sum, saturate, scale and write back.
  logic                 s1_valid;
  logic signed [DW-1:0] s1_dry;
  logic                 s1_tap;
  logic [OW-1:0]        s1_wp;
  logic                 fwd;
  logic [SW-1:0]        fwd_data;

  logic signed [SW-1:0] tap_word;
  logic signed [DW:0]   sum;
  logic signed [SW-1:0] sat;
  logic signed [DW-1:0] mult_in;
  logic signed [16:0]   gain_s;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_adj;
  logic [SW-1:0]        store_word;
  logic                 s1_go;

  always_comb begin
    tap_word = s1_tap ? $signed(fwd ? fwd_data : mem_q) : '0;
    sum      = (DW+1)'(s1_dry) + (DW+1)'(tap_word);
    priority if (sum > (DW+1)'(gfdl_pkg::SAMPLE_MAX)) begin
      sat = gfdl_pkg::SAMPLE_MAX;
    end else if (sum < (DW+1)'(gfdl_pkg::SAMPLE_MIN)) begin
      sat = gfdl_pkg::SAMPLE_MIN;
    end else begin
      sat = sum[SW-1:0];
    end
    mult_in  = (delay_mode == gfdl_pkg::MODE_SLAP) ? s1_dry : DW'(sat);
    gain_s   = $signed({1'b0, feedback_gain});
    prod     = mult_in * gain_s;
    // Round toward zero: bias negative products before the shift.
    prod_adj = prod + (prod[PW-1] ? $signed(PW'(32767)) : $signed(PW'(0)));
    store_word = prod_adj[gfdl_pkg::Q15_SHIFT +: SW];
  end

  assign s1_go  = adv && s1_valid;
  assign mem_we = clearing || s1_go;
  assign mem_wa = clearing ? clr_addr : s1_wp;
  assign mem_wd = clearing ? '0 : store_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go) begin
      s1_dry   <= s0_dry;
      s1_tap   <= (current_next != '0);
      s1_wp    <= wp;
      // Forward the word written this edge when the read hit the same entry.
      fwd      <= s1_valid && (rd_addr == s1_wp);
      fwd_data <= store_word;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      sample_out <= sat;
    end
  end

endmodule
